// ----- hw/rtl/sndx_pkg.sv -----
// ----------------------------------------------------------------------------
// sndx_pkg: shared types and constants for the soundex key encoder
// Holds the queue entry layout, queue status, ASCII constants and code table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sndx_pkg;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [6:0] KEY_LETTER_A  = 7'h41;
  localparam logic [6:0] KEY_LETTER_Z  = 7'h5A;
  localparam logic [5:0] KEY_DIGIT_0   = 6'h30;
  localparam int unsigned DIGIT_COUNT  = 3;

  // One classified item: a terminator, or a letter with its index and code.
  typedef struct packed {
    logic       term;
    logic [4:0] idx;
    logic [2:0] code;
  } sndx_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sndx_qstat_t;

  function automatic logic [2:0] letter_code(input logic [4:0] idx);
    logic [2:0] c;
    case (idx)
      5'd0:  c = 3'd0;  5'd1:  c = 3'd1;  5'd2:  c = 3'd2;  5'd3:  c = 3'd3;
      5'd4:  c = 3'd0;  5'd5:  c = 3'd1;  5'd6:  c = 3'd2;  5'd7:  c = 3'd0;
      5'd8:  c = 3'd0;  5'd9:  c = 3'd2;  5'd10: c = 3'd2;  5'd11: c = 3'd4;
      5'd12: c = 3'd5;  5'd13: c = 3'd5;  5'd14: c = 3'd0;  5'd15: c = 3'd1;
      5'd16: c = 3'd2;  5'd17: c = 3'd6;  5'd18: c = 3'd2;  5'd19: c = 3'd3;
      5'd20: c = 3'd0;  5'd21: c = 3'd1;  5'd22: c = 3'd0;  5'd23: c = 3'd2;
      5'd24: c = 3'd0;  5'd25: c = 3'd2;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sndx_front.sv -----
// ----------------------------------------------------------------------------
// sndx_front: byte classifier
// Accepts bytes, drops non-letters except the zero terminator, maps letters to index and code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sndx_front import sndx_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  sndx_qstat_t q_stat,
  output logic        push,
  output sndx_entry_t push_entry
);

  logic       is_upper;
  logic       is_lower;
  logic       is_term;
  logic [7:0] offset;

  assign in_ready = !q_stat.full;
  assign is_term  = (in_char_byte == 8'h00);
  assign is_upper = (in_char_byte >= ASCII_UPPER_A) && (in_char_byte <= ASCII_UPPER_Z);
  assign is_lower = (in_char_byte >= ASCII_LOWER_A) && (in_char_byte <= ASCII_LOWER_Z);

  always_comb begin
    if (is_lower) begin
      offset = in_char_byte - ASCII_LOWER_A;
    end else begin
      offset = in_char_byte - ASCII_UPPER_A;
    end
    push_entry.term = is_term;
    push_entry.idx  = offset[4:0];
    push_entry.code = letter_code(offset[4:0]);
  end

  // Drop non-letters other than the zero terminator here: accept them but push nothing.
  assign push = in_valid && in_ready && (is_term || is_upper || is_lower);

endmodule

// ----- hw/rtl/sndx_queue.sv -----
// ----------------------------------------------------------------------------
// sndx_queue: two-entry item queue
// Decouples the classifier from the key builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sndx_queue import sndx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sndx_entry_t push_entry,
  input  logic        pop,
  output sndx_entry_t pop_entry,
  output sndx_qstat_t q_stat
);

  sndx_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_entry    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/sndx_back.sv -----
// ----------------------------------------------------------------------------
// sndx_back: key builder
// Tracks first letter and code digits, emits the key on a terminator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sndx_back import sndx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sndx_qstat_t q_stat,
  input  sndx_entry_t pop_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_key_letter,
  output logic [5:0]  out_key_digit_one,
  output logic [5:0]  out_key_digit_two,
  output logic [5:0]  out_key_digit_three
);

  logic       have_r, have_nxt;
  logic [2:0] prev_r, prev_nxt;
  logic [1:0] filled_r, filled_nxt;
  logic [4:0] first_r, first_nxt;
  logic [2:0] dig_r [DIGIT_COUNT];
  logic [2:0] dig_nxt [DIGIT_COUNT];
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] key_letter_r;
  logic [5:0] key_d1_r, key_d2_r, key_d3_r;
  logic       slot_free;
  logic       emit;

  assign slot_free = !out_valid_r || out_ready;
  assign pop  = !q_stat.empty && (!pop_entry.term || slot_free);
  assign emit = pop && pop_entry.term;

  always_comb begin
    have_nxt   = have_r;
    prev_nxt   = prev_r;
    filled_nxt = filled_r;
    first_nxt  = first_r;
    dig_nxt    = dig_r;
    if (emit) begin
      have_nxt   = 1'b0;
      prev_nxt   = 3'd0;
      filled_nxt = 2'd0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        dig_nxt[i] = 3'd0;
      end
    end else if (pop) begin
      if (!have_r) begin
        have_nxt  = 1'b1;
        first_nxt = pop_entry.idx;
        prev_nxt  = pop_entry.code;
      end else if ((filled_r != 2'd3) && (pop_entry.code != prev_r)) begin
        prev_nxt = pop_entry.code;
        if (pop_entry.code != 3'd0) begin
          dig_nxt[filled_r] = pop_entry.code;
          filled_nxt        = filled_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      prev_r      <= 3'd0;
      filled_r    <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        dig_r[i] <= 3'd0;
      end
    end else begin
      have_r      <= have_nxt;
      prev_r      <= prev_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
      dig_r       <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    if (emit) begin
      key_letter_r <= have_r ? (KEY_LETTER_A + {2'b00, first_r}) : KEY_LETTER_Z;
      key_d1_r     <= KEY_DIGIT_0 + {3'b000, dig_r[0]};
      key_d2_r     <= KEY_DIGIT_0 + {3'b000, dig_r[1]};
      key_d3_r     <= KEY_DIGIT_0 + {3'b000, dig_r[2]};
    end
  end

  assign out_valid           = out_valid_r;
  assign out_key_letter      = key_letter_r;
  assign out_key_digit_one   = key_d1_r;
  assign out_key_digit_two   = key_d2_r;
  assign out_key_digit_three = key_d3_r;

endmodule

// ----- hw/rtl/soundex_key_encoder.sv -----
// ----------------------------------------------------------------------------
// soundex_key_encoder: streaming phonetic key encoder
// Takes a string one byte per item and emits a four-character key on a
// zero byte.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_char_byte        | input
//   out     | out_valid, out_ready, out_key_letter,   | output
//           | out_key_digit_one/two/three             |
//
// Sustains one byte per cycle while the queue is not full; the classify
// step and the key update run on separate items.
// A key shows on the output once its zero byte, written to the queue when
// accepted, is popped into the output register.
// Reset clears the queue, the key state and the output valid; no sweep.
// A stalled output blocks only terminator items; letters keep flowing until
// the two-entry queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soundex_key_encoder import sndx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_key_letter,
  output logic [5:0] out_key_digit_one,
  output logic [5:0] out_key_digit_two,
  output logic [5:0] out_key_digit_three
);

  sndx_qstat_t q_stat;
  sndx_entry_t push_entry;
  sndx_entry_t pop_entry;
  logic        push;
  logic        pop;

  // Front: classify each byte, drop non-letters other than the zero terminator.
  sndx_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Queue: lets the front keep taking bytes while the back waits on output.
  sndx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // Back: advance the key state, hold a finished key in the output register.
  sndx_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .pop_entry           (pop_entry),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_key_letter      (out_key_letter),
    .out_key_digit_one   (out_key_digit_one),
    .out_key_digit_two   (out_key_digit_two),
    .out_key_digit_three (out_key_digit_three)
  );

  // Output is idle right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A shown key has an uppercase letter.
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_letter >= KEY_LETTER_A) && (out_key_letter <= KEY_LETTER_Z))
    else $error("key letter out of range");

  // A shown key has digits '0'..'6'.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_digit_one >= 6'h30) && (out_key_digit_one <= 6'h36)
              && (out_key_digit_two >= 6'h30) && (out_key_digit_two <= 6'h36)
              && (out_key_digit_three >= 6'h30) && (out_key_digit_three <= 6'h36))
    else $error("key digit out of range");

  // Input backpressure only comes from a full queue, which can never be empty.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> !q_stat.empty)
    else $error("in_ready low with empty queue");

  // The queue never pops while empty.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("queue underflow");

endmodule
